FILE: hw/rtl/dma_ring_receive_fifo_unit_macros.svh
// assertion helpers for the rtl
`ifndef DMA_RING_RECEIVE_FIFO_UNIT_MACROS_SVH
`define DMA_RING_RECEIVE_FIFO_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DMARX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DMARX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dmarx_pkg.sv
`timescale 1ns / 1ps

package dmarx_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECEIVE = 2'd0,
        CMD_READ    = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_CLEAR   = 2'd3
    } dmarx_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_RUN,
        ST_RD_EMPTY
    } dmarx_state_t;

endpackage

FILE: hw/rtl/dmarx_if.sv
`timescale 1ns / 1ps

// command request channel
interface dmarx_in_if;
    logic                             valid;
    logic                             ready;
    logic [dmarx_pkg::CMD_W-1:0]      cmd;
    logic [dmarx_pkg::BYTE_W-1:0]     rx_byte;
    logic [dmarx_pkg::LIMIT_W-1:0]    read_limit;

    modport source (output valid, output cmd, output rx_byte, output read_limit,
                    input ready);
    modport sink   (input valid, input cmd, input rx_byte, input read_limit,
                    output ready);
endinterface

// read result channel
interface dmarx_out_if;
    logic                             valid;
    logic                             ready;
    logic [dmarx_pkg::BYTE_W-1:0]     out_byte;
    logic                             has_byte;
    logic                             last;
    logic                             overrun;

    modport source (output valid, output out_byte, output has_byte, output last,
                    output overrun, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input last,
                    input overrun, output ready);
endinterface

FILE: hw/rtl/dmarx_ram.sv
`timescale 1ns / 1ps

// simple dual-port ram, one write and one registered read port
module dmarx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dma_ring_receive_fifo_unit.sv
// dma_ring_receive_fifo_unit: ring receive buffer written like a circular dma channel
//
// req channel (valid/ready) carries one command per request: receive a byte,
// read, update the fill level, or clear. rsp channel (valid/ready) carries
// read results; only a read request produces results.
// receive, update and clear complete on acceptance. a read updates the level
// on acceptance, then, while rsp is not stalled, issues one ram read per cycle
// for up to read_limit bytes (clamped to 1..MAX_READ and to the level); the
// single ram read port sets that rate. a byte goes from its ram read through
// the ram data and result registers to rsp. a read on an empty buffer gives
// one result with has_byte low and last high. new requests are taken once the
// read has issued its last ram access, so bytes still in flight overlap the
// next one. a stalled rsp holds the result register and the ram data register; ram
// reads stop until the data register drains, so nothing is dropped.
// reset puts the down-counter and its snapshot at DEPTH and clears level,
// read position and overrun; the ring store is not cleared, so it needs no
// pass after reset and requests are taken right away.
`timescale 1ns / 1ps
`include "dma_ring_receive_fifo_unit_macros.svh"

module dma_ring_receive_fifo_unit #(
    parameter int DEPTH    = 256,
    parameter int MAX_READ = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    dmarx_in_if.sink    req,
    dmarx_out_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = dmarx_pkg::LIMIT_W;
    localparam int MW = (CW > LW) ? CW : LW;
    localparam int BW = dmarx_pkg::BYTE_W;

    // control state
    dmarx_pkg::dmarx_state_t state_reg, state_next;
    logic [CW-1:0] dma_count_reg, dma_count_next;
    logic [CW-1:0] seen_count_reg, seen_count_next;
    logic [CW-1:0] fill_level_reg, fill_level_next;
    logic          overrun_reg, overrun_next;
    logic [AW-1:0] read_pos_reg, read_pos_next;
    logic [LW-1:0] rem_reg, rem_next;

    // ram data stage (data itself sits in the ram read register)
    logic          dq_valid_reg, dq_valid_next;
    logic          dq_last_reg, dq_last_next;
    logic          dq_ovr_reg, dq_ovr_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] out_byte_reg, out_byte_next;
    logic          out_has_reg, out_has_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovr_reg, out_ovr_next;

    dmarx_pkg::dmarx_cmd_t cmd;
    logic          req_fire;
    logic          req_ready;
    logic          out_free;
    logic          dq_take;
    logic          issue;
    logic          empty_load;

    logic [CW-1:0] delta;
    logic [CW:0]   sum;
    logic          upd_sat;
    logic [CW-1:0] upd_fill;
    logic          upd_ovr;
    logic [LW-1:0] limit_c;
    logic [LW-1:0] n_read;
    logic [CW-1:0] wdiff;
    logic [AW-1:0] wpos;
    logic [AW-1:0] read_pos_inc;
    logic [BW-1:0] ram_rdata;

    assign cmd      = dmarx_pkg::dmarx_cmd_t'(req.cmd);
    assign req_fire = req.valid && req_ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign dq_take  = dq_valid_reg && out_free;

    // level update: counter movement since last snapshot, modulo DEPTH
    always_comb
    begin
        if (dma_count_reg > seen_count_reg)
        begin
            delta = CW'(DEPTH) + seen_count_reg - dma_count_reg;
        end
        else
        begin
            delta = seen_count_reg - dma_count_reg;
        end
        sum      = {1'b0, fill_level_reg} + {1'b0, delta};
        upd_sat  = sum > (CW + 1)'(DEPTH);
        upd_fill = upd_sat ? CW'(DEPTH) : sum[CW-1:0];
        upd_ovr  = overrun_reg || upd_sat;
    end

    // read length: limit clamped to 1..MAX_READ, then to the level
    always_comb
    begin
        priority if (req.read_limit == '0)
        begin
            limit_c = LW'(1);
        end
        else if (req.read_limit > LW'(MAX_READ))
        begin
            limit_c = LW'(MAX_READ);
        end
        else
        begin
            limit_c = req.read_limit;
        end
        if (MW'(upd_fill) < MW'(limit_c))
        begin
            n_read = LW'(upd_fill);
        end
        else
        begin
            n_read = limit_c;
        end
    end

    // write position is DEPTH minus the down-counter
    assign wdiff        = CW'(DEPTH) - dma_count_reg;
    assign wpos         = wdiff[AW-1:0];
    assign read_pos_inc = (read_pos_reg == AW'(DEPTH - 1)) ? '0 : read_pos_reg + AW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmarx_pkg::ST_IDLE:
            begin
                if (req_fire && cmd == dmarx_pkg::CMD_READ)
                begin
                    state_next = (upd_fill == '0) ? dmarx_pkg::ST_RD_EMPTY
                                                  : dmarx_pkg::ST_RD_RUN;
                end
            end
            dmarx_pkg::ST_RD_RUN:
            begin
                if (issue && rem_reg == LW'(1))
                begin
                    state_next = dmarx_pkg::ST_IDLE;
                end
            end
            dmarx_pkg::ST_RD_EMPTY:
            begin
                if (empty_load)
                begin
                    state_next = dmarx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmarx_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready  = 1'b0;
        issue      = 1'b0;
        empty_load = 1'b0;
        unique case (state_reg)
            dmarx_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            dmarx_pkg::ST_RD_RUN:
            begin
                // one ram read in flight at most, data stage must be free
                issue = !dq_valid_reg || dq_take;
            end
            dmarx_pkg::ST_RD_EMPTY:
            begin
                // empty result goes out after any bytes still in flight
                empty_load = !dq_valid_reg && out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign req.ready = req_ready;

    // level, counter and read position
    always_comb
    begin
        dma_count_next  = dma_count_reg;
        seen_count_next = seen_count_reg;
        fill_level_next = fill_level_reg;
        overrun_next    = overrun_reg;
        read_pos_next   = read_pos_reg;
        rem_next        = rem_reg;
        if (req_fire)
        begin
            unique case (cmd)
                dmarx_pkg::CMD_RECEIVE:
                begin
                    dma_count_next = (dma_count_reg <= CW'(1)) ? CW'(DEPTH)
                                                               : dma_count_reg - CW'(1);
                end
                dmarx_pkg::CMD_READ:
                begin
                    fill_level_next = upd_fill;
                    overrun_next    = upd_ovr;
                    seen_count_next = dma_count_reg;
                    rem_next        = n_read;
                end
                dmarx_pkg::CMD_UPDATE:
                begin
                    fill_level_next = upd_fill;
                    overrun_next    = upd_ovr;
                    seen_count_next = dma_count_reg;
                end
                dmarx_pkg::CMD_CLEAR:
                begin
                    seen_count_next = dma_count_reg;
                    read_pos_next   = wpos;
                    fill_level_next = '0;
                    overrun_next    = 1'b0;
                end
            endcase
        end
        else if (issue)
        begin
            read_pos_next   = read_pos_inc;
            fill_level_next = fill_level_reg - CW'(1);
            rem_next        = rem_reg - LW'(1);
        end
    end

    // ram data stage and result register
    always_comb
    begin
        dq_valid_next  = dq_valid_reg;
        dq_last_next   = dq_last_reg;
        dq_ovr_next    = dq_ovr_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;
        out_ovr_next   = out_ovr_reg;

        if (issue)
        begin
            dq_valid_next = 1'b1;
            dq_last_next  = (rem_reg == LW'(1));
            dq_ovr_next   = overrun_reg;
        end
        else if (dq_take)
        begin
            dq_valid_next = 1'b0;
        end

        priority if (dq_take)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_has_next   = 1'b1;
            out_last_next  = dq_last_reg;
            out_ovr_next   = dq_ovr_reg;
        end
        else if (empty_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_has_next   = 1'b0;
            out_last_next  = 1'b1;
            out_ovr_next   = overrun_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dmarx_pkg::ST_IDLE;
            dma_count_reg  <= CW'(DEPTH);
            seen_count_reg <= CW'(DEPTH);
            fill_level_reg <= '0;
            overrun_reg    <= 1'b0;
            read_pos_reg   <= '0;
            rem_reg        <= '0;
            dq_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dma_count_reg  <= dma_count_next;
            seen_count_reg <= seen_count_next;
            fill_level_reg <= fill_level_next;
            overrun_reg    <= overrun_next;
            read_pos_reg   <= read_pos_next;
            rem_reg        <= rem_next;
            dq_valid_reg   <= dq_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        dq_last_reg  <= dq_last_next;
        dq_ovr_reg   <= dq_ovr_next;
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_ovr_reg  <= out_ovr_next;
    end

    // ring store
    dmarx_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (req_fire && cmd == dmarx_pkg::CMD_RECEIVE),
        .waddr (wpos),
        .wdata (req.rx_byte),
        .re    (issue),
        .raddr (read_pos_reg),
        .rdata (ram_rdata)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;
    assign rsp.has_byte = out_has_reg;
    assign rsp.last     = out_last_reg;
    assign rsp.overrun  = out_ovr_reg;

    // checks
    `DMARX_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_level_reg <= CW'(DEPTH),
        "fill level above depth")
    `DMARX_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1,
        dma_count_reg != '0 && dma_count_reg <= CW'(DEPTH),
        "dma counter out of range")
    `DMARX_ASSERT_NOW(a_rem_covered, clk, rst_n, state_reg == dmarx_pkg::ST_RD_RUN,
        rem_reg != '0 && MW'(rem_reg) <= MW'(fill_level_reg),
        "read count exceeds fill level")
    `DMARX_ASSERT_NEXT(a_dq_hold, clk, rst_n, dq_valid_reg && out_valid_reg && !rsp.ready,
        dq_valid_reg, "ram data dropped under stall")

endmodule
